// ===== hw/rtl/kcet_pkg.sv =====
// Shared types, constants and saturating arithmetic for the clock error tracker.
// No dependencies; used by every module of the block.
package kcet_pkg;

  localparam int FRAC_BITS_DEF = 32;
  localparam int DW = 64;
  localparam int PW = 6;

  localparam logic [48:0] RST_Q_POS    = 49'd4294967296;
  localparam logic [48:0] RST_Q_CROSS  = 49'd30064771;
  localparam logic [48:0] RST_Q_RATE   = 49'd188979;
  localparam logic [60:0] RST_MEAS_NSE = 61'd214748364800000;
  localparam logic [60:0] RST_INIT_VAR = 61'd42949672960000000;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  // Register indexes on the config port
  typedef enum logic [2:0] {
    REG_Q_POS   = 3'd0,
    REG_Q_CROSS = 3'd1,
    REG_Q_RATE  = 3'd2,
    REG_MEAS    = 3'd3,
    REG_INIT    = 3'd4
  } reg_idx_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_INIT,
    OP_P1,
    OP_P2,
    OP_P3,
    OP_P4,
    OP_UPD,
    OP_DIV_KE_GO,
    OP_DIV_KR_GO,
    OP_KE_SET,
    OP_KR_SET,
    OP_MUL_GO,
    OP_MUL_APPLY,
    OP_OUT
  } op_t;

  // Gain products, in the order they are applied
  typedef enum logic [2:0] {
    M_KEY,
    M_KRY,
    M_KEE,
    M_KRER,
    M_KEER
  } msel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_P1,
    S_P2,
    S_P3,
    S_P4,
    S_UPD,
    S_CHK,
    S_DKE_GO,
    S_DKE_WT,
    S_DKR_GO,
    S_DKR_WT,
    S_M_GO,
    S_M_WT,
    S_FIN
  } state_t;

  typedef struct packed {
    op_t   op;
    msel_t msel;
  } dp_cmd_t;

  typedef struct packed {
    logic s_pos;
    logic div_done;
    logic mul_done;
  } dp_stat_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    mag64 = a[63] ? (64'd0 - 64'(a)) : 64'(a);
  endfunction

  // Clamp a signed magnitude to the signed 64-bit range
  function automatic logic signed [63:0] sat_mag(input logic neg, input logic [127:0] m);
    logic ovf;
    ovf = (m[127:63] != 65'd0);
    if (neg) begin
      sat_mag = ovf ? S64_MIN : $signed(64'd0 - m[63:0]);
    end else begin
      sat_mag = ovf ? S64_MAX : $signed(m[63:0]);
    end
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) add_sat = s[64] ? S64_MIN : S64_MAX;
    else add_sat = s[63:0];
  endfunction

  function automatic logic signed [63:0] sub_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s[64] != s[63]) sub_sat = s[64] ? S64_MIN : S64_MAX;
    else sub_sat = s[63:0];
  endfunction

endpackage

// ===== hw/rtl/kalman_clock_error_tracker.sv =====
// Two-state clock error Kalman tracker, top level: config registers and wiring.
// Depends on kcet_pkg, kcet_ctrl, kcet_dp.
// Run time is set by the bit-serial gain divider, run twice, and the five gain products;
// the first item skips the predict steps, and the divides are skipped when S is not positive.
// A new item is taken only once the previous result is registered, which waits while the output is stalled.
// Reset (rst_n low, synchronous): estimate and covariance cleared, config registers to defaults.
module kalman_clock_error_tracker #(
  parameter int FRAC_BITS = kcet_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_measurement,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_est_error,
  output logic signed [63:0] out_est_rate,
  output logic [62:0]        out_error_variance,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [kcet_pkg::PW-1:0] paddr,
  input  logic [kcet_pkg::DW-1:0] pwdata,
  output logic [kcet_pkg::DW-1:0] prdata,
  output logic               pready
);
  import kcet_pkg::*;

  logic [48:0] q_pos_r, q_cross_r, q_rate_r;
  logic [60:0] r_meas_r, init_var_r;
  logic        wr_en;
  reg_idx_t    ridx;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign ridx   = reg_idx_t'(paddr[5:3]);

  // Config register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_pos_r    <= RST_Q_POS;
      q_cross_r  <= RST_Q_CROSS;
      q_rate_r   <= RST_Q_RATE;
      r_meas_r   <= RST_MEAS_NSE;
      init_var_r <= RST_INIT_VAR;
    end else if (wr_en) begin
      unique case (ridx)
        REG_Q_POS:   q_pos_r    <= pwdata[48:0];
        REG_Q_CROSS: q_cross_r  <= pwdata[48:0];
        REG_Q_RATE:  q_rate_r   <= pwdata[48:0];
        REG_MEAS:    r_meas_r   <= pwdata[60:0];
        REG_INIT:    init_var_r <= pwdata[60:0];
        default: ;
      endcase
    end
  end

  // Readback
  always_comb begin
    unique case (ridx)
      REG_Q_POS:   prdata = 64'(q_pos_r);
      REG_Q_CROSS: prdata = 64'(q_cross_r);
      REG_Q_RATE:  prdata = 64'(q_rate_r);
      REG_MEAS:    prdata = 64'(r_meas_r);
      REG_INIT:    prdata = 64'(init_var_r);
      default:     prdata = 64'd0;
    endcase
  end

  kcet_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .stat(stat)
  );

  kcet_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cmd(cmd), .stat(stat),
    .meas(in_measurement),
    .q_pos(q_pos_r), .q_cross(q_cross_r), .q_rate(q_rate_r),
    .r_meas(r_meas_r), .init_var(init_var_r),
    .est_error(out_est_error), .est_rate(out_est_rate),
    .error_variance(out_error_variance)
  );

endmodule

// ===== hw/rtl/kcet_mul.sv =====
// Sequential signed Q-format multiplier: four 32x32 partial products.
// Depends on kcet_pkg.
module kcet_mul #(
  parameter int FRAC_BITS = kcet_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic               done,
  output logic signed [63:0] res
);
  import kcet_pkg::*;

  logic [63:0]  ma_r, mb_r;
  logic         neg_r;
  logic [127:0] acc_r, acc_nxt;
  logic [63:0]  pp_r;
  logic [1:0]   sh_r;
  logic [2:0]   cnt_r;
  logic         busy_r, done_r;
  logic [31:0]  opa, opb;
  logic [127:0] acc_sh;

  // Operand halves per step
  always_comb begin
    case (cnt_r)
      3'd0:    begin opa = ma_r[31:0];  opb = mb_r[31:0];  end
      3'd1:    begin opa = ma_r[63:32]; opb = mb_r[31:0];  end
      3'd2:    begin opa = ma_r[31:0];  opb = mb_r[63:32]; end
      default: begin opa = ma_r[63:32]; opb = mb_r[63:32]; end
    endcase
  end

  always_comb begin
    case (sh_r)
      2'd0:    acc_nxt = acc_r + 128'(pp_r);
      2'd1:    acc_nxt = acc_r + (128'(pp_r) << 32);
      default: acc_nxt = acc_r + (128'(pp_r) << 64);
    endcase
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: product register, then accumulate
  always_ff @(posedge clk) begin
    if (start) begin
      ma_r  <= mag64(a);
      mb_r  <= mag64(b);
      neg_r <= a[63] ^ b[63];
      acc_r <= 128'd0;
    end else if (busy_r) begin
      if (cnt_r != 3'd4) begin
        pp_r <= opa * opb;
        sh_r <= (cnt_r == 3'd0) ? 2'd0 : ((cnt_r == 3'd3) ? 2'd2 : 2'd1);
      end
      if (cnt_r != 3'd0) acc_r <= acc_nxt;
    end
  end

  assign acc_sh = acc_r >> FRAC_BITS;
  assign res    = sat_mag(neg_r, acc_sh);
  assign done   = done_r;

endmodule

// ===== hw/rtl/kcet_div.sv =====
// Restoring divider for Q-format gains, one quotient bit per cycle.
// Depends on kcet_pkg.
module kcet_div #(
  parameter int FRAC_BITS = kcet_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] d,
  output logic               done,
  output logic signed [63:0] res
);
  import kcet_pkg::*;

  localparam int NW = 64 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_r;
  logic [63:0]   rem_r, d_r;
  logic          neg_r, busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [64:0]   rr, diff;
  logic          ge;

  assign rr   = {rem_r, num_r[NW-1]};
  assign diff = rr - {1'b0, d_r};
  assign ge   = ~diff[64];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift numerator out, quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= {mag64(a), {FRAC_BITS{1'b0}}};
      rem_r <= 64'd0;
      d_r   <= 64'(d);
      neg_r <= a[63];
    end else if (busy_r) begin
      rem_r <= ge ? diff[63:0] : rr[63:0];
      num_r <= {num_r[NW-2:0], ge};
    end
  end

  assign res  = sat_mag(neg_r, 128'(num_r));
  assign done = done_r;

endmodule

// ===== hw/rtl/kcet_dp.sv =====
// Filter datapath: state, covariance, shared multiplier and divider.
// Depends on kcet_pkg, kcet_mul, kcet_div.
module kcet_dp #(
  parameter int FRAC_BITS = kcet_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  kcet_pkg::dp_cmd_t      cmd,
  output kcet_pkg::dp_stat_t     stat,
  input  logic signed [31:0]     meas,
  input  logic [48:0]            q_pos,
  input  logic [48:0]            q_cross,
  input  logic [48:0]            q_rate,
  input  logic [60:0]            r_meas,
  input  logic [60:0]            init_var,
  output logic signed [63:0]     est_error,
  output logic signed [63:0]     est_rate,
  output logic [62:0]            error_variance
);
  import kcet_pkg::*;

  logic signed [31:0] meas_r;
  logic signed [63:0] e_r, r_r, pee_r, per_r, prr_r, ta_r, tb_r;
  logic signed [63:0] y_r, s_r, ke_r, kr_r;
  logic signed [63:0] oe_r, or_r;
  logic [62:0]        ov_r;
  logic signed [63:0] z, ma, mb, mres, dres, da;
  logic               mdone, ddone, mstart, dstart;
  logic [127:0]       zm;

  // Measurement scaled to Q
  assign zm = 128'(mag64(64'(meas_r))) << FRAC_BITS;
  assign z  = sat_mag(meas_r[31], zm);

  // Multiplier operand select
  always_comb begin
    case (cmd.msel)
      M_KEY:   begin ma = ke_r; mb = y_r;   end
      M_KRY:   begin ma = kr_r; mb = y_r;   end
      M_KEE:   begin ma = ke_r; mb = pee_r; end
      M_KRER:  begin ma = kr_r; mb = per_r; end
      M_KEER:  begin ma = ke_r; mb = per_r; end
      default: begin ma = ke_r; mb = y_r;   end
    endcase
  end

  assign mstart = (cmd.op == OP_MUL_GO);
  assign dstart = (cmd.op == OP_DIV_KE_GO) || (cmd.op == OP_DIV_KR_GO);
  assign da     = (cmd.op == OP_DIV_KR_GO) ? per_r : pee_r;

  kcet_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mstart), .a(ma), .b(mb),
    .done(mdone), .res(mres)
  );

  kcet_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .a(da), .d(s_r),
    .done(ddone), .res(dres)
  );

  // State and covariance registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_r   <= '0;
      r_r   <= '0;
      pee_r <= '0;
      per_r <= '0;
      prr_r <= '0;
    end else begin
      case (cmd.op)
        OP_CAPTURE: meas_r <= meas;
        OP_INIT: begin
          pee_r <= $signed(64'(init_var));
          prr_r <= $signed(64'(init_var));
          per_r <= '0;
        end
        OP_P1: begin
          e_r  <= add_sat(e_r, r_r);
          ta_r <= add_sat(pee_r, per_r);
          tb_r <= add_sat(per_r, prr_r);
        end
        OP_P2: begin
          ta_r  <= add_sat(ta_r, per_r);
          per_r <= add_sat(tb_r, $signed(64'(q_cross)));
        end
        OP_P3: begin
          ta_r  <= add_sat(ta_r, prr_r);
          prr_r <= add_sat(prr_r, $signed(64'(q_rate)));
        end
        OP_P4: pee_r <= add_sat(ta_r, $signed(64'(q_pos)));
        OP_UPD: begin
          y_r  <= sub_sat(z, e_r);
          s_r  <= add_sat(pee_r, $signed(64'(r_meas)));
          ke_r <= '0;
          kr_r <= '0;
        end
        OP_KE_SET: ke_r <= dres;
        OP_KR_SET: kr_r <= dres;
        OP_MUL_APPLY: begin
          case (cmd.msel)
            M_KEY:   e_r   <= add_sat(e_r, mres);
            M_KRY:   r_r   <= add_sat(r_r, mres);
            M_KEE:   pee_r <= sub_sat(pee_r, mres);
            M_KRER:  prr_r <= sub_sat(prr_r, mres);
            M_KEER:  per_r <= sub_sat(per_r, mres);
            default: ;
          endcase
        end
        OP_OUT: begin
          oe_r <= e_r;
          or_r <= r_r;
          ov_r <= pee_r[63] ? 63'd0 : pee_r[62:0];
        end
        default: ;
      endcase
    end
  end

  assign stat.s_pos    = ~s_r[63] && (s_r != 64'sd0);
  assign stat.div_done = ddone;
  assign stat.mul_done = mdone;

  assign est_error      = oe_r;
  assign est_rate       = or_r;
  assign error_variance = ov_r;

endmodule

// ===== hw/rtl/kcet_ctrl.sv =====
// Sequencer: steps first-item init or predict, gain divides, gain products and result handoff.
// Depends on kcet_pkg.
module kcet_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output kcet_pkg::dp_cmd_t  cmd,
  input  kcet_pkg::dp_stat_t stat
);
  import kcet_pkg::*;

  state_t state_r, state_nxt;
  msel_t  msel_r, msel_nxt;
  logic   started_r, started_nxt;
  logic   ov_r, ov_nxt;
  logic   accept, out_free;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign out_free = !ov_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt   = state_r;
    msel_nxt    = msel_r;
    started_nxt = started_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = started_r ? S_P1 : S_INIT;
      S_INIT: begin
        started_nxt = 1'b1;
        state_nxt   = S_UPD;
      end
      S_P1:     state_nxt = S_P2;
      S_P2:     state_nxt = S_P3;
      S_P3:     state_nxt = S_P4;
      S_P4:     state_nxt = S_UPD;
      S_UPD: begin
        msel_nxt  = M_KEY;
        state_nxt = S_CHK;
      end
      S_CHK:    state_nxt = stat.s_pos ? S_DKE_GO : S_M_GO;
      S_DKE_GO: state_nxt = S_DKE_WT;
      S_DKE_WT: if (stat.div_done) state_nxt = S_DKR_GO;
      S_DKR_GO: state_nxt = S_DKR_WT;
      S_DKR_WT: if (stat.div_done) state_nxt = S_M_GO;
      S_M_GO:   state_nxt = S_M_WT;
      S_M_WT: begin
        if (stat.mul_done) begin
          if (msel_r == M_KEER) begin
            state_nxt = S_FIN;
          end else begin
            msel_nxt  = msel_t'(msel_r + 3'd1);
            state_nxt = S_M_GO;
          end
        end
      end
      S_FIN:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd.op   = OP_NONE;
    cmd.msel = msel_r;
    unique case (state_r)
      S_IDLE:   if (accept) cmd.op = OP_CAPTURE;
      S_INIT:   cmd.op = OP_INIT;
      S_P1:     cmd.op = OP_P1;
      S_P2:     cmd.op = OP_P2;
      S_P3:     cmd.op = OP_P3;
      S_P4:     cmd.op = OP_P4;
      S_UPD:    cmd.op = OP_UPD;
      S_DKE_GO: cmd.op = OP_DIV_KE_GO;
      S_DKE_WT: if (stat.div_done) cmd.op = OP_KE_SET;
      S_DKR_GO: cmd.op = OP_DIV_KR_GO;
      S_DKR_WT: if (stat.div_done) cmd.op = OP_KR_SET;
      S_M_GO:   cmd.op = OP_MUL_GO;
      S_M_WT:   if (stat.mul_done) cmd.op = OP_MUL_APPLY;
      S_FIN:    if (out_free) cmd.op = OP_OUT;
      default:  cmd.op = OP_NONE;
    endcase
  end

  // Output valid
  always_comb begin
    ov_nxt = ov_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    if (state_r == S_FIN && out_free) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      msel_r    <= M_KEY;
      started_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      msel_r    <= msel_nxt;
      started_r <= started_nxt;
      ov_r      <= ov_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;

endmodule

// ===== bench/kalman_clock_error_tracker_test.sv =====
// Testbench for the clock error Kalman tracker: random measurements, APB register phases,
// a bit-exact Q32.32 filter predictor inside a small scoreboard class. Depends on kcet_pkg.
module kalman_clock_error_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;
  import kcet_pkg::*;

  localparam logic signed [63:0] MAXQ = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] MINQ = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic signed [63:0] err;
    logic signed [63:0] rate;
    logic [62:0]        var_ee;
  } estimate_t;

  // Filter predictor and queue of predicted estimates
  class filter_tracker;
    logic [48:0] q_pos, q_cross, q_rate;
    logic [60:0] r_meas, p_init;
    logic signed [63:0] x_e, x_r, p_ee, p_er, p_rr;
    bit primed;
    estimate_t pending[$];
    int mismatches;

    function new();
      q_pos = RST_Q_POS; q_cross = RST_Q_CROSS; q_rate = RST_Q_RATE;
      r_meas = RST_MEAS_NSE; p_init = RST_INIT_VAR;
      x_e = 0; x_r = 0; p_ee = 0; p_er = 0; p_rr = 0; primed = 0;
      mismatches = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [63:0] v);
      case (idx)
        REG_Q_POS:   q_pos = v[48:0];
        REG_Q_CROSS: q_cross = v[48:0];
        REG_Q_RATE:  q_rate = v[48:0];
        REG_MEAS:    r_meas = v[60:0];
        REG_INIT:    p_init = v[60:0];
        default: ;
      endcase
    endfunction

    function logic signed [63:0] clamp(logic neg, logic [127:0] m);
      if (neg) return (m > 128'h8000_0000_0000_0000) ? MINQ : -$signed({1'b0, m[63:0]});
      return (m > 128'h7FFF_FFFF_FFFF_FFFF) ? MAXQ : $signed(m[63:0]);
    endfunction

    function logic [63:0] absv(logic signed [63:0] a);
      return a[63] ? 64'd0 - a : a;
    endfunction

    function logic signed [63:0] sadd(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s > 65'sd9223372036854775807) return MAXQ;
      if (s < -65'sd9223372036854775808) return MINQ;
      return s[63:0];
    endfunction

    function logic signed [63:0] ssub(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s > 65'sd9223372036854775807) return MAXQ;
      if (s < -65'sd9223372036854775808) return MINQ;
      return s[63:0];
    endfunction

    function logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
      logic [127:0] p;
      p = {64'd0, absv(a)} * {64'd0, absv(b)};
      return clamp(a[63] != b[63], p >> 32);
    endfunction

    function logic signed [63:0] qdiv(logic signed [63:0] a, logic signed [63:0] d);
      logic [127:0] n;
      n = {64'd0, absv(a)} << 32;
      return clamp(a[63], n / {64'd0, d});
    endfunction

    function void note_measurement(logic signed [31:0] m);
      logic signed [63:0] z, y, s, ke, kr, ee, er;
      estimate_t est;
      ke = 0; kr = 0;
      if (!primed) begin
        p_ee = {3'd0, p_init}; p_rr = {3'd0, p_init}; p_er = 0; primed = 1;
      end else begin
        x_e = sadd(x_e, x_r);
        ee = sadd(sadd(sadd(p_ee, p_er), p_er), p_rr);
        p_ee = sadd(ee, {15'd0, q_pos});
        p_er = sadd(sadd(p_er, p_rr), {15'd0, q_cross});
        p_rr = sadd(p_rr, {15'd0, q_rate});
      end
      z = {m, 32'd0};
      y = ssub(z, x_e);
      s = sadd(p_ee, {3'd0, r_meas});
      if (s > 0) begin
        ke = qdiv(p_ee, s);
        kr = qdiv(p_er, s);
      end
      x_e = sadd(x_e, qmul(ke, y));
      x_r = sadd(x_r, qmul(kr, y));
      ee = ssub(p_ee, qmul(ke, p_ee));
      er = ssub(p_er, qmul(ke, p_er));
      p_rr = ssub(p_rr, qmul(kr, p_er));
      p_ee = ee; p_er = er;
      est.err = x_e; est.rate = x_r;
      est.var_ee = p_ee[63] ? 63'd0 : p_ee[62:0];
      pending.push_back(est);
    endfunction

    function void check_estimate(logic signed [63:0] e, logic signed [63:0] r,
                                 logic [62:0] v);
      estimate_t x;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item err=%0d", e);
        return;
      end
      x = pending.pop_front();
      if (x.err !== e || x.rate !== r || x.var_ee !== v) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp err=%0d rate=%0d var=%0d, got err=%0d rate=%0d var=%0d",
                   x.err, x.rate, x.var_ee, e, r, v);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] in_measurement = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [63:0] out_est_error, out_est_rate;
  logic [62:0] out_error_variance;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [PW-1:0] paddr = 0;
  logic [DW-1:0] pwdata = 0;
  logic [DW-1:0] prdata;
  logic pready;
  filter_tracker tracker;
  bit sink_busy = 0;

  kalman_clock_error_tracker dut (.*);

  always #6 clk = ~clk;

  // Hard limit on run time
  initial begin
    #500ms;
    $display("FAILURE");
    $finish;
  end

  // Result side: random stalls, check each accepted item
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_estimate(out_est_error, out_est_rate, out_error_variance);
  end

  initial begin
    int w;
    forever begin
      @(posedge clk);
      if (sink_busy) begin
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (w != 0) begin
          out_stall <= 1;
          repeat (w) @(posedge clk);
          out_stall <= 0;
        end
        do @(posedge clk); while (!(out_valid && !out_stall));
      end
    end
  end

  // Each write returns to idle before the task ends so back-to-back calls never collide
  task automatic write_reg(reg_idx_t idx, logic [63:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= PW'(idx) << 3; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    tracker.write_reg(idx, v);
    @(posedge clk);
  endtask

  // Valid drops after accept only when an idle gap follows the item
  task automatic send_measurement(logic signed [31:0] m, bit burst);
    int gap;
    in_valid <= 1; in_measurement <= m;
    do @(posedge clk); while (in_stall);
    tracker.note_measurement(m);
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_valid <= 0;
    while (tracker.pending.size() != 0 && n < 100000) begin
      @(posedge clk); n++;
    end
    repeat (300) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_meas(int mode);
    case (mode)
      0: return $signed($urandom());
      1: return $signed($urandom_range(0, 2000)) - 1000;
      default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endcase
  endfunction

  initial begin
    logic signed [31:0] drift;
    bit burst;
    tracker = new();
    sink_busy = 1;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: default registers, extremes and sign flips
    send_measurement(32'sh7FFF_FFFF, 0);
    send_measurement(32'sh8000_0000, 0);
    send_measurement(0, 0);
    send_measurement(-1, 0);
    send_measurement(1, 1);
    send_measurement(32'sh8000_0000, 1);
    send_measurement(32'sh7FFF_FFFF, 1);
    drain();
    // Zero measurement noise: S can be zero once variance collapses
    write_reg(REG_MEAS, 0);
    write_reg(REG_INIT, 0);
    for (int i = 0; i < 6; i++) send_measurement(rand_meas(0), 0);
    drain();
    // Large noise and variance values (top bit of each register set)
    write_reg(REG_Q_POS, 64'd281474976710656);
    write_reg(REG_Q_CROSS, 64'd281474976710656);
    write_reg(REG_Q_RATE, 64'd281474976710656);
    write_reg(REG_MEAS, 64'd1152921504606846976);
    write_reg(REG_INIT, 64'd1152921504606846976);
    for (int i = 0; i < 8; i++) send_measurement(rand_meas(2), 0);
    drain();
    // Random phases with random register values
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_Q_POS, {$urandom(), $urandom()} & 64'h1_FFFF_FFFF_FFFF >> $urandom_range(0, 30));
      write_reg(REG_Q_CROSS, {$urandom(), $urandom()} & 64'h1_FFFF_FFFF_FFFF >> $urandom_range(0, 40));
      write_reg(REG_Q_RATE, {$urandom(), $urandom()} & 64'h1_FFFF_FFFF_FFFF >> $urandom_range(0, 45));
      write_reg(REG_MEAS, ({$urandom(), $urandom()} & 64'h1FFF_FFFF_FFFF_FFFF
                           >> $urandom_range(0, 50)) | 64'd1);
      write_reg(REG_INIT, {$urandom(), $urandom()} & 64'h1FFF_FFFF_FFFF_FFFF
                          >> $urandom_range(0, 50));
      drift = $signed($urandom_range(0, 200)) - 100;
      for (int i = 0; i < 140; i++) begin
        burst = (ph % 3 == 0);
        if ($urandom_range(0, 9) < 7) send_measurement(drift * i + rand_meas(1), burst);
        else send_measurement(rand_meas($urandom_range(0, 2)), burst);
      end
      drain();
    end
    // Back to reset defaults
    write_reg(REG_Q_POS, RST_Q_POS);
    write_reg(REG_Q_CROSS, RST_Q_CROSS);
    write_reg(REG_Q_RATE, RST_Q_RATE);
    write_reg(REG_MEAS, RST_MEAS_NSE);
    write_reg(REG_INIT, RST_INIT_VAR);
    for (int i = 0; i < 20; i++) send_measurement(rand_meas(1), 0);
    drain();
    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
